// ===== rtl/edf_pkg.sv =====
// shared constants, payload types and cell control struct for the edf slice scheduler
// no dependencies; used by the interfaces, the cell and the top level
package edf_pkg;

    localparam int TASK_SLOTS = 8;
    localparam int TIME_BITS  = 16;

    // fixed port field widths
    localparam int SLOT_W     = 3;
    localparam int FIELD_W    = 16;
    localparam int COUNT_W    = 4;

    localparam int SLOT_BITS  = $clog2(TASK_SLOTS);
    localparam int IDX_BITS   = (SLOT_BITS > SLOT_W) ? SLOT_BITS : SLOT_W;
    localparam int CMP_BITS   = ((IDX_BITS > COUNT_W) ? IDX_BITS : COUNT_W) + 1;

    localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};
    localparam logic [COUNT_W-1:0]   COUNT_RESET = COUNT_W'(3);

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // partial result that travels down the row of cells
    typedef struct packed {
        logic                 valid;
        logic                 found;
        logic [IDX_BITS-1:0]  best_slot;
        logic [TIME_BITS-1:0] best_due;
        logic [1:0]           busy_cnt;   // nonzero budgets seen, saturates at 2
        logic                 best_one;   // winner has exactly one slice left
    } t_wave;

    // broadcast writes into the cells
    typedef struct packed {
        logic                 load_en;
        logic                 dec_en;
        logic [IDX_BITS-1:0]  slot;
        logic [TIME_BITS-1:0] arrival;
        logic [TIME_BITS-1:0] budget;
        logic [TIME_BITS-1:0] due;
    } t_cell_ctl;

endpackage

// ===== rtl/edf_if.sv =====
// valid/ready channel interfaces for the scheduler input and result words
// depends on edf_pkg for field widths
interface edf_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [edf_pkg::SLOT_W-1:0]    slot;
    logic [edf_pkg::FIELD_W-1:0]   arrival;
    logic [edf_pkg::FIELD_W-1:0]   budget;
    logic [edf_pkg::FIELD_W-1:0]   due_slice;

    modport source (output valid, command, slot, arrival, budget, due_slice, input ready);
    modport sink   (input valid, command, slot, arrival, budget, due_slice, output ready);
endinterface

interface edf_out_if;
    logic                          valid;
    logic                          ready;
    logic                          picked;
    logic [edf_pkg::SLOT_W-1:0]    picked_slot;
    logic [edf_pkg::FIELD_W-1:0]   slice_time;
    logic                          all_done;

    modport source (output valid, picked, picked_slot, slice_time, all_done, input ready);
    modport sink   (input valid, picked, picked_slot, slice_time, all_done, output ready);
endinterface

// ===== rtl/edf_cell.sv =====
// one task slot: holds arrival, deadline and remaining budget, and folds
// itself into the passing scan word; depends on edf_pkg
module edf_cell (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [edf_pkg::IDX_BITS-1:0]      i_index,
    input  logic [edf_pkg::COUNT_W-1:0]       i_count,
    input  logic [edf_pkg::TIME_BITS-1:0]     i_now,
    input  edf_pkg::t_cell_ctl                i_ctl,
    input  edf_pkg::t_wave                    i_wave,
    output edf_pkg::t_wave                    o_wave
);

    logic [edf_pkg::TIME_BITS-1:0] r_arrival;
    logic [edf_pkg::TIME_BITS-1:0] r_due;
    logic [edf_pkg::TIME_BITS-1:0] r_rem;
    edf_pkg::t_wave                r_wave;
    edf_pkg::t_wave                n_wave;

    logic w_sel;
    logic w_active;
    logic w_busy;
    logic w_take;

    assign w_sel    = (i_ctl.slot == i_index);
    assign w_active = (edf_pkg::CMP_BITS'(i_index) < edf_pkg::CMP_BITS'(i_count));
    assign w_busy   = w_active && (r_rem != '0);
    assign w_take   = i_wave.valid && w_busy && (r_arrival <= i_now) &&
                      (!i_wave.found || (r_due < i_wave.best_due));

    always_comb begin
        n_wave       = i_wave;
        n_wave.found = i_wave.found | w_take;
        if (w_take) begin
            n_wave.best_slot = i_index;
            n_wave.best_due  = r_due;
            n_wave.best_one  = (r_rem == edf_pkg::TIME_BITS'(1));
        end
        if (w_busy && (i_wave.busy_cnt != 2'd2)) begin
            n_wave.busy_cnt = i_wave.busy_cnt + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_en && w_sel) begin
            r_arrival <= i_ctl.arrival;
            r_due     <= i_ctl.due;
            r_rem     <= i_ctl.budget;
        end else if (i_ctl.dec_en && w_sel) begin
            r_rem <= r_rem - edf_pkg::TIME_BITS'(1);
        end
    end

    // payload only moves with the scan word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave.valid <= 1'b0;
        end else begin
            r_wave.valid <= i_wave.valid;
        end
        if (i_wave.valid) begin
            r_wave.found     <= n_wave.found;
            r_wave.best_slot <= n_wave.best_slot;
            r_wave.best_due  <= n_wave.best_due;
            r_wave.busy_cnt  <= n_wave.busy_cnt;
            r_wave.best_one  <= n_wave.best_one;
        end
    end

    assign o_wave = r_wave;

endmodule

// ===== rtl/edf_slice_scheduler.sv =====
// a tick's result word is registered after the scan word walks the row of cells one slot
// per cycle and the pick state commits it; no new word is accepted until that commit
// a load is written into its slot when it is accepted, which happens only in the idle state
// a result word held by the receiver stalls the next tick in the pick state
// reset: synchronous active low; clears slice clock, halt flag, task_count to 3
// and the output valid; slot contents stay undefined until loaded
module edf_slice_scheduler (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [edf_pkg::COUNT_W-1:0]   i_cfg_wdata,
    edf_in_if.sink                        i_in,
    edf_out_if.source                     o_out
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_PICK = 3'b100
    } t_state;

    t_state                          r_state;
    t_state                          n_state;
    logic [edf_pkg::COUNT_W-1:0]     r_count;
    logic [edf_pkg::TIME_BITS-1:0]   r_now;
    logic                            r_halted;

    logic                            r_out_valid;
    logic                            r_out_picked;
    logic [edf_pkg::SLOT_W-1:0]      r_out_slot;
    logic [edf_pkg::FIELD_W-1:0]     r_out_time;
    logic                            r_out_done;

    edf_pkg::t_wave                  w_wave [edf_pkg::TASK_SLOTS];
    edf_pkg::t_wave                  w_start;
    edf_pkg::t_wave                  w_last;
    edf_pkg::t_cell_ctl              w_ctl;

    logic w_in_fire;
    logic w_launch;
    logic w_commit;
    logic w_done;

    assign i_in.ready = (r_state == S_IDLE);
    assign w_in_fire  = i_in.valid && i_in.ready;
    assign w_launch   = w_in_fire && (i_in.command == edf_pkg::CMD_TICK) && !r_halted;
    assign w_last     = w_wave[edf_pkg::TASK_SLOTS-1];
    assign w_commit   = (r_state == S_PICK) && (!r_out_valid || o_out.ready);
    // only the winner was busy and it has just spent its last slice
    assign w_done     = w_last.found && (w_last.busy_cnt == 2'd1) && w_last.best_one;

    always_comb begin
        w_start           = '0;
        w_start.valid     = w_launch;

        w_ctl.load_en     = w_in_fire && (i_in.command == edf_pkg::CMD_LOAD);
        w_ctl.dec_en      = w_commit && w_last.found;
        w_ctl.slot        = w_ctl.load_en ? edf_pkg::IDX_BITS'(i_in.slot) : w_last.best_slot;
        w_ctl.arrival     = edf_pkg::TIME_BITS'(i_in.arrival);
        w_ctl.budget      = edf_pkg::TIME_BITS'(i_in.budget);
        w_ctl.due         = edf_pkg::TIME_BITS'(i_in.due_slice);
    end

    for (genvar g = 0; g < edf_pkg::TASK_SLOTS; g++) begin : g_cell
        edf_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_index (edf_pkg::IDX_BITS'(g)),
            .i_count (r_count),
            .i_now   (r_now),
            .i_ctl   (w_ctl),
            .i_wave  ((g == 0) ? w_start : w_wave[(g == 0) ? 0 : g-1]),
            .o_wave  (w_wave[g])
        );
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_launch) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (w_last.valid) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= edf_pkg::COUNT_RESET;
            r_now       <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_count <= i_cfg_wdata;
            end
            if (w_commit) begin
                r_out_valid <= 1'b1;
                r_halted    <= w_done;
                if (r_now != edf_pkg::TIME_MAX) begin
                    r_now <= r_now + edf_pkg::TIME_BITS'(1);
                end
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_out_picked <= w_last.found;
            r_out_slot   <= w_last.found ? edf_pkg::SLOT_W'(w_last.best_slot) : '0;
            r_out_time   <= edf_pkg::FIELD_W'(r_now);
            r_out_done   <= w_done;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.picked      = r_out_picked;
    assign o_out.picked_slot = r_out_slot;
    assign o_out.slice_time  = r_out_time;
    assign o_out.all_done    = r_out_done;

    a_halt_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_halted) |-> (o_out.valid && o_out.all_done))
        else $error("halt set without an all_done word");

    a_scan_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_last.valid |-> (r_state == S_SCAN))
        else $error("scan word left the row outside a scan");

    a_no_pick_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_commit && !w_last.found) |=> (o_out.picked_slot == '0 && !o_out.all_done))
        else $error("empty pick carries a slot or a halt");

    a_halted_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_halted && w_in_fire) |=> (r_state == S_IDLE))
        else $error("tick started a scan while halted");

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// testbench for edf_slice_scheduler: streams task loads and slice ticks, checks every pick word
// against an in-bench earliest-deadline-first model; uses edf_pkg, edf_in_if and edf_out_if
module tb_top;

    // copies of the scheduler state: checked against the block, planned ahead, trial run
    localparam int LIVE  = 0;
    localparam int PLAN  = 1;
    localparam int PROBE = 2;

    localparam int SETTLE       = edf_pkg::TASK_SLOTS + 6;
    localparam int RANDOM_ITEMS = 1330;
    localparam int CALM_FROM    = 300;
    localparam int CALM_TO      = 520;
    localparam int HOLD_AT      = 760;
    localparam int HOLD_CYCLES  = 600;
    localparam int STALL_LIMIT  = 5000;
    localparam int IDLE_PCT     = 37;
    localparam int TIME_TOP     = int'(edf_pkg::TIME_MAX);
    localparam int OP_LOAD      = int'(edf_pkg::CMD_LOAD);
    localparam int OP_TICK      = int'(edf_pkg::CMD_TICK);

    typedef struct packed {
        logic                        command;
        logic [edf_pkg::SLOT_W-1:0]  slot;
        logic [edf_pkg::FIELD_W-1:0] arrival;
        logic [edf_pkg::FIELD_W-1:0] budget;
        logic [edf_pkg::FIELD_W-1:0] due_slice;
    } t_sched_word;

    typedef struct packed {
        logic                        picked;
        logic [edf_pkg::SLOT_W-1:0]  picked_slot;
        logic [edf_pkg::FIELD_W-1:0] slice_time;
        logic                        all_done;
    } t_pick_word;

    typedef struct packed {
        logic                        is_cfg;
        logic [edf_pkg::COUNT_W-1:0] count;
        t_sched_word                 word;
    } t_pending;

    logic                        clk;
    logic                        rst_n;
    logic                        cfg_we;
    logic [edf_pkg::COUNT_W-1:0] cfg_wdata;

    edf_in_if  in_ch ();
    edf_out_if out_ch ();

    edf_slice_scheduler dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch),
        .o_out       (out_ch)
    );

    logic [edf_pkg::TIME_BITS-1:0] arrival_tab [3][edf_pkg::TASK_SLOTS];
    logic [edf_pkg::TIME_BITS-1:0] budget_tab  [3][edf_pkg::TASK_SLOTS];
    logic [edf_pkg::TIME_BITS-1:0] due_tab     [3][edf_pkg::TASK_SLOTS];
    logic [edf_pkg::TIME_BITS-1:0] slice_clk   [3];
    logic                          halted      [3];
    logic [edf_pkg::COUNT_W-1:0]   task_count  [3];

    t_pending   pending_q[$];
    t_pick_word expected_picks[$];

    int planned_items   = 0;
    int sat_from        = 1 << 30;
    int in_count        = 0;
    int quiet           = 0;
    int hold_left       = 0;
    bit hold_done       = 1'b0;
    int stall_cycles    = 0;
    int errors          = 0;
    int results_checked = 0;
    int picks_seen      = 0;
    int halts_seen      = 0;
    int cfg_writes      = 0;

    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic bit calm_now();
        return (in_count >= CALM_FROM && in_count < CALM_TO) || in_count >= sat_from;
    endfunction

    function automatic t_sched_word make_word(input int cmd, input int s, input int a,
                                              input int b, input int d);
        t_sched_word w;
        w.command   = 1'(cmd);
        w.slot      = edf_pkg::SLOT_W'(s);
        w.arrival   = edf_pkg::FIELD_W'(a);
        w.budget    = edf_pkg::FIELD_W'(b);
        w.due_slice = edf_pkg::FIELD_W'(d);
        return w;
    endfunction

    task automatic reset_model(input int c);
        for (int i = 0; i < edf_pkg::TASK_SLOTS; i++) begin
            arrival_tab[c][i] = '0;
            budget_tab[c][i]  = '0;
            due_tab[c][i]     = '0;
        end
        slice_clk[c]  = '0;
        halted[c]     = 1'b0;
        task_count[c] = edf_pkg::COUNT_RESET;
    endtask

    // one word through the scheduler: a load writes a slot, a tick picks the earliest deadline
    task automatic run_scheduler(input int c, input t_sched_word w, output bit produced,
                                 output t_pick_word r);
        int                            n;
        bit                            found;
        bit                            done;
        logic [edf_pkg::SLOT_W-1:0]    best;
        logic [edf_pkg::TIME_BITS-1:0] best_due;
        r        = '0;
        produced = 1'b0;
        found    = 1'b0;
        done     = 1'b0;
        best     = '0;
        best_due = '0;
        n = (task_count[c] > edf_pkg::TASK_SLOTS) ? edf_pkg::TASK_SLOTS : task_count[c];
        if (w.command == edf_pkg::CMD_LOAD) begin
            if (w.slot < edf_pkg::TASK_SLOTS) begin
                arrival_tab[c][w.slot] = w.arrival;
                budget_tab[c][w.slot]  = w.budget;
                due_tab[c][w.slot]     = w.due_slice;
            end
        end else if (!halted[c]) begin
            for (int i = 0; i < n; i++) begin
                if (arrival_tab[c][i] <= slice_clk[c] && budget_tab[c][i] != '0 &&
                    (!found || due_tab[c][i] < best_due)) begin
                    found    = 1'b1;
                    best     = edf_pkg::SLOT_W'(i);
                    best_due = due_tab[c][i];
                end
            end
            if (found) begin
                budget_tab[c][best] = budget_tab[c][best] - edf_pkg::TIME_BITS'(1);
                done = 1'b1;
                for (int i = 0; i < n; i++) begin
                    if (budget_tab[c][i] != '0)
                        done = 1'b0;
                end
                halted[c] = done;
            end
            produced      = 1'b1;
            r.picked      = found;
            r.picked_slot = found ? best : '0;
            r.slice_time  = edf_pkg::FIELD_W'(slice_clk[c]);
            r.all_done    = done;
            if (slice_clk[c] != edf_pkg::TIME_MAX)
                slice_clk[c] = slice_clk[c] + edf_pkg::TIME_BITS'(1);
        end
    endtask

    task automatic plan_word(input t_sched_word w);
        t_pending   p;
        bit         produced;
        t_pick_word r;
        p        = '0;
        p.word   = w;
        pending_q.push_back(p);
        run_scheduler(PLAN, w, produced, r);
        planned_items++;
    endtask

    task automatic plan_config(input logic [edf_pkg::COUNT_W-1:0] value);
        t_pending p;
        p        = '0;
        p.is_cfg = 1'b1;
        p.count  = value;
        pending_q.push_back(p);
        task_count[PLAN] = value;
    endtask

    // a tick that would drain the table is preceded by fresh work, unless halting is wanted
    task automatic plan_tick(input bit may_halt);
        t_sched_word w;
        bit          produced;
        t_pick_word  r;
        int          n;
        w = make_word(OP_TICK, $urandom_range(7), $urandom, $urandom, $urandom);
        for (int i = 0; i < edf_pkg::TASK_SLOTS; i++) begin
            arrival_tab[PROBE][i] = arrival_tab[PLAN][i];
            budget_tab[PROBE][i]  = budget_tab[PLAN][i];
            due_tab[PROBE][i]     = due_tab[PLAN][i];
        end
        slice_clk[PROBE]  = slice_clk[PLAN];
        halted[PROBE]     = halted[PLAN];
        task_count[PROBE] = task_count[PLAN];
        run_scheduler(PROBE, w, produced, r);
        if (produced && r.all_done && !may_halt) begin
            n = (task_count[PLAN] > edf_pkg::TASK_SLOTS) ? edf_pkg::TASK_SLOTS
                                                          : task_count[PLAN];
            plan_word(make_word(OP_LOAD, $urandom_range(n - 1),
                                $urandom_range(int'(slice_clk[PLAN])), $urandom_range(2, 9),
                                int'(slice_clk[PLAN]) + $urandom_range(12)));
        end
        plan_word(w);
    endtask

    // task arriving around the current slice with a short budget and a close deadline
    task automatic plan_near_load();
        int n;
        int clk_now;
        n = (task_count[PLAN] > edf_pkg::TASK_SLOTS) ? edf_pkg::TASK_SLOTS : task_count[PLAN];
        if (n == 0)
            n = edf_pkg::TASK_SLOTS;
        clk_now = int'(slice_clk[PLAN]);
        plan_word(make_word(OP_LOAD,
                            ($urandom_range(9) == 0) ? $urandom_range(7) : $urandom_range(n - 1),
                            ((clk_now > 3) ? clk_now - 3 : 0) + $urandom_range(6),
                            ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 5),
                            clk_now + $urandom_range(12)));
    endtask

    // driver: offers queued words, applies register writes once the block is drained
    always @(posedge clk) begin : drive_words
        t_sched_word w;
        t_pending    p;
        bit          produced;
        t_pick_word  r;
        bit          take;
        bit          valid_next;
        bit          we_next;
        if (!rst_n) begin
            in_ch.valid <= 1'b0;
            cfg_we      <= 1'b0;
            quiet       <= 0;
        end else begin
            take       = in_ch.valid && in_ch.ready;
            valid_next = in_ch.valid && !take;
            we_next    = 1'b0;
            if (take) begin
                w.command   = in_ch.command;
                w.slot      = in_ch.slot;
                w.arrival   = in_ch.arrival;
                w.budget    = in_ch.budget;
                w.due_slice = in_ch.due_slice;
                run_scheduler(LIVE, w, produced, r);
                if (produced)
                    expected_picks.push_back(r);
                in_count <= in_count + 1;
                quiet    <= 0;
            end else if (quiet < SETTLE) begin
                quiet <= quiet + 1;
            end
            if (!valid_next && pending_q.size() != 0) begin
                if (pending_q[0].is_cfg) begin
                    if (!take && !cfg_we && quiet >= SETTLE && expected_picks.size() == 0) begin
                        p       = pending_q.pop_front();
                        we_next = 1'b1;
                        cfg_wdata <= p.count;
                        task_count[LIVE] = p.count;
                        cfg_writes++;
                    end
                end else if (calm_now() || $urandom_range(99) >= IDLE_PCT) begin
                    p          = pending_q.pop_front();
                    valid_next = 1'b1;
                    in_ch.command   <= p.word.command;
                    in_ch.slot      <= p.word.slot;
                    in_ch.arrival   <= p.word.arrival;
                    in_ch.budget    <= p.word.budget;
                    in_ch.due_slice <= p.word.due_slice;
                end
            end
            in_ch.valid <= valid_next;
            cfg_we      <= we_next;
        end
    end

    // receiver: random stalls plus one long hold-off so the block backs up
    always @(posedge clk) begin
        if (!rst_n) begin
            out_ch.ready <= 1'b0;
            hold_left    <= 0;
        end else if (hold_left != 0) begin
            out_ch.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (!hold_done && in_count >= HOLD_AT) begin
            out_ch.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            out_ch.ready <= calm_now() || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk) begin : check_picks
        t_pick_word got;
        t_pick_word want;
        if (rst_n && out_ch.valid && out_ch.ready) begin
            got.picked      = out_ch.picked;
            got.picked_slot = out_ch.picked_slot;
            got.slice_time  = out_ch.slice_time;
            got.all_done    = out_ch.all_done;
            if (expected_picks.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("pick word with none pending: picked=%0b slot=%0d time=%0d done=%0b",
                             got.picked, got.picked_slot, got.slice_time, got.all_done);
            end else begin
                want = expected_picks.pop_front();
                if (got.picked !== want.picked || got.picked_slot !== want.picked_slot ||
                    got.slice_time !== want.slice_time || got.all_done !== want.all_done) begin
                    errors++;
                    if (errors <= 10)
                        $display("pick word %0d: expected %0b/%0d/%0d/%0b, got %0b/%0d/%0d/%0b",
                                 results_checked, want.picked, want.picked_slot,
                                 want.slice_time, want.all_done, got.picked,
                                 got.picked_slot, got.slice_time, got.all_done);
                end
                results_checked++;
                if (got.picked === 1'b1)
                    picks_seen++;
                if (got.all_done === 1'b1)
                    halts_seen++;
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", stall_cycles);
            $display("CHECKS FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin : run_test
        logic [edf_pkg::COUNT_W-1:0] cfg_list [8];
        int                          phase;
        int                          directed_end;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_wdata       = '0;
        in_ch.valid     = 1'b0;
        in_ch.command   = edf_pkg::CMD_LOAD;
        in_ch.slot      = '0;
        in_ch.arrival   = '0;
        in_ch.budget    = '0;
        in_ch.due_slice = '0;
        out_ch.ready    = 1'b0;
        reset_model(LIVE);
        reset_model(PLAN);

        // directed: tie on deadline, extreme values, spent budgets, default slot count
        plan_word(make_word(OP_LOAD, 0, 0, 2, 10));
        plan_word(make_word(OP_LOAD, 1, 0, 1, 10));
        plan_word(make_word(OP_LOAD, 2, TIME_TOP, TIME_TOP, TIME_TOP));
        for (int s = 3; s < edf_pkg::TASK_SLOTS; s++)
            plan_word(make_word(OP_LOAD, s, 0, 0, 0));
        repeat (4) plan_tick(1'b0);
        plan_config(4'd8);
        // all-ones deadline still runs; a later arrival with an earlier deadline runs once it arrives
        plan_word(make_word(OP_LOAD, 3, 0, 1, TIME_TOP));
        plan_word(make_word(OP_LOAD, 6, 5, 2, 7));
        repeat (3) plan_tick(1'b0);
        directed_end = planned_items;

        cfg_list = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd5, 4'd9, 4'd2, 4'd8};
        phase    = 0;
        while (planned_items < directed_end + RANDOM_ITEMS) begin
            if (phase < 8 && planned_items - directed_end >= phase * (RANDOM_ITEMS / 8)) begin
                plan_config(cfg_list[phase]);
                phase++;
            end
            if ($urandom_range(99) < 10) begin
                if ($urandom_range(1) == 1)
                    plan_tick(1'b0);
                else
                    plan_word(make_word(OP_LOAD, $urandom_range(7), $urandom, $urandom,
                                        $urandom));
            end else begin
                repeat ($urandom_range(3)) plan_near_load();
                repeat ($urandom_range(1, 6)) plan_tick(1'b0);
            end
        end

        // tasks that arrive at the last slice never run, then halt the table
        sat_from = planned_items;
        for (int s = 0; s < edf_pkg::TASK_SLOTS; s++)
            plan_word(make_word(OP_LOAD, s, TIME_TOP, $urandom_range(100, 65535), $urandom));
        repeat (3) plan_tick(1'b0);
        for (int s = 0; s < edf_pkg::TASK_SLOTS; s++)
            plan_word(make_word(OP_LOAD, s, 0, (s == 4) ? 2 : 0, TIME_TOP));
        repeat (4) plan_tick(1'b1);
        plan_word(make_word(OP_LOAD, 4, 0, 5, 0));
        plan_tick(1'b1);

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        while (pending_q.size() != 0 || in_ch.valid || expected_picks.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (expected_picks.size() != 0) begin
            errors += expected_picks.size();
            $display("%0d expected pick words never arrived", expected_picks.size());
        end
        $display("covered %0d input words and %0d register writes; %0d pick words checked",
                 in_count, cfg_writes, results_checked);
        $display("%0d ticks ran a task, %0d halted the table, ticks ignored after the halt",
                 picks_seen, halts_seen);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches", errors);
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/edf_pkg.sv
rtl/edf_if.sv
rtl/edf_cell.sv
rtl/edf_slice_scheduler.sv
test/tb_top.sv
